// ===== hw/rtl/kca_pkg.sv =====
// ----------------------------------------------------------------------------
// kca_pkg
// Shared constants, types and helper functions for the annotated k-mer
// counter: table geometry, controller commands and datapath status.
// ----------------------------------------------------------------------------
package kca_pkg;

   // Table geometry: one row of slots for each annotation class.
   localparam int SLOT_COUNT  = 65536;
   localparam int CLASS_COUNT = 5;
   localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
   localparam int TABLE_DEPTH = CLASS_COUNT * SLOT_COUNT;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

   // Field widths.
   localparam int CHAR_W  = 8;
   localparam int CLASS_W = 3;
   localparam int RUN_W   = 5;
   localparam int COUNT_W = 8;
   localparam int TOTAL_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // Only the slot bits of the rolling word are ever observed.
   localparam int WORD_BITS = SLOT_BITS;

   localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIXED_CLASS = 2'd1;

   localparam logic [RUN_W-1:0]   WORD_LENGTH_RESET = 5'd24;
   localparam logic [CLASS_W-1:0] MIXED_CLASS_RESET = 3'd4;

   // Base codes; bit 2 marks a non-ACGT byte.
   localparam logic [2:0] BASE_A    = 3'd0;
   localparam logic [2:0] BASE_C    = 3'd1;
   localparam logic [2:0] BASE_G    = 3'd2;
   localparam logic [2:0] BASE_T    = 3'd3;
   localparam logic [2:0] BASE_WILD = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;    // write one zero entry of the clearing pass
      logic capture;  // take the request payload
      logic update;   // advance the window state
      logic lookup;   // read the table slot
      logic modify;   // saturating increment and write-back
      logic deliver;  // load the result register and counters
   } kca_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;  // the clearing pass is at its last entry
      logic out_free;    // the result register can take a new result
   } kca_status_type;

   // Map a nucleotide byte, either case, to its 3-bit base code.
   function automatic logic [2:0] base_code(input logic [CHAR_W-1:0] c);
      logic [2:0] code;
      case (c)
         8'h41, 8'h61: code = BASE_A;
         8'h43, 8'h63: code = BASE_C;
         8'h47, 8'h67: code = BASE_G;
         8'h54, 8'h74: code = BASE_T;
         default:      code = BASE_WILD;
      endcase
      return code;
   endfunction

   // Saturating increment of a run length.
   function automatic logic [RUN_W-1:0] run_bump(input logic [RUN_W-1:0] r);
      return (r == RUN_MAX) ? RUN_MAX : r + RUN_W'(1);
   endfunction

endpackage

// ===== hw/rtl/kca_ram.sv =====
// ----------------------------------------------------------------------------
// kca_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read. Read data holds when no read is issued.
// ----------------------------------------------------------------------------
module kca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/kca_ctrl.sv =====
// ----------------------------------------------------------------------------
// kca_ctrl
// Controller of the k-mer counter: runs the table clearing pass after reset,
// then steps each request through update, lookup, modify and deliver.
// ----------------------------------------------------------------------------
module kca_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  kca_pkg::kca_status_type status,
   output kca_pkg::kca_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR   = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_UPDATE  = 6'b000100,
      ST_LOOKUP  = 6'b001000,
      ST_MODIFY  = 6'b010000,
      ST_DELIVER = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_MODIFY;
         end
         ST_MODIFY: begin
            cmd.modify = 1'b1;
            state_in   = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (status.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // A request is taken only when the datapath is free.
   assign req_stall = (state_ff != ST_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/kca_datapath.sv =====
// ----------------------------------------------------------------------------
// kca_datapath
// Datapath of the k-mer counter: configuration registers, rolling window
// state, count table with its clearing pass, counters and result register.
// ----------------------------------------------------------------------------
module kca_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kca_pkg::kca_cmd_type                 cmd,
   output kca_pkg::kca_status_type              status,
   // Request payload.
   input  logic [kca_pkg::CHAR_W-1:0]           req_base_char,
   input  logic [kca_pkg::CLASS_W-1:0]          req_annot_class,
   input  logic                                 req_end_of_sequence,
   // Configuration writes.
   input  logic                                 csr_wr_en,
   input  logic [kca_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [kca_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_window_complete,
   output logic                                 rsp_wild_window,
   output logic [kca_pkg::SLOT_BITS-1:0]        rsp_slot_index,
   output logic [kca_pkg::CLASS_W-1:0]          rsp_word_class,
   output logic [kca_pkg::COUNT_W-1:0]          rsp_new_count,
   output logic [kca_pkg::TOTAL_W-1:0]          rsp_total_windows,
   output logic [kca_pkg::TOTAL_W-1:0]          rsp_wild_windows
);

   // Configuration.
   logic [kca_pkg::RUN_W-1:0]   word_length_ff, word_length_in;
   logic [kca_pkg::CLASS_W-1:0] mixed_class_ff, mixed_class_in;

   // Captured request.
   logic [kca_pkg::CHAR_W-1:0]  base_ff, base_in;
   logic [kca_pkg::CLASS_W-1:0] annot_ff, annot_in;
   logic                        last_ff, last_in;

   // Window state.
   logic [kca_pkg::WORD_BITS-1:0] word_ff, word_in;
   logic [kca_pkg::RUN_W-1:0]     bases_ff, bases_in;
   logic [kca_pkg::RUN_W-1:0]     valid_run_ff, valid_run_in;
   logic [kca_pkg::RUN_W-1:0]     same_run_ff, same_run_in;
   logic [kca_pkg::CLASS_W-1:0]   last_annot_ff, last_annot_in;

   // Per-request working result.
   logic                          complete_ff, complete_in;
   logic                          wild_ff, wild_in;
   logic                          countable_ff, countable_in;
   logic [kca_pkg::SLOT_BITS-1:0] slot_ff, slot_in;
   logic [kca_pkg::CLASS_W-1:0]   class_ff, class_in;
   logic [kca_pkg::COUNT_W-1:0]   count_ff, count_in;

   // Running counters.
   logic [kca_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [kca_pkg::TOTAL_W-1:0] wild_cnt_ff, wild_cnt_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_complete_ff, rsp_complete_in;
   logic                          rsp_wild_ff, rsp_wild_in;
   logic [kca_pkg::SLOT_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   logic [kca_pkg::CLASS_W-1:0]   rsp_class_ff, rsp_class_in;
   logic [kca_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // Clearing pass.
   logic [kca_pkg::TABLE_AW-1:0] clr_addr_ff, clr_addr_in;

   // Combinational window update.
   logic [2:0]                    code;
   logic                          wild_base;
   logic [kca_pkg::RUN_W-1:0]     k_eff;
   logic [kca_pkg::RUN_W-1:0]     same_next;
   logic [kca_pkg::RUN_W-1:0]     bases_next;
   logic [kca_pkg::RUN_W-1:0]     valid_next;
   logic [kca_pkg::WORD_BITS-1:0] word_next;
   logic [kca_pkg::WORD_BITS-1:0] word_mask;
   logic                          complete_next;
   logic                          wild_next;
   logic [kca_pkg::CLASS_W-1:0]   class_next;

   // Table access.
   logic                         tbl_wr_en;
   logic [kca_pkg::TABLE_AW-1:0] tbl_wr_addr;
   logic [kca_pkg::COUNT_W-1:0]  tbl_wr_data;
   logic [kca_pkg::TABLE_AW-1:0] tbl_addr;
   logic [kca_pkg::COUNT_W-1:0]  tbl_rd_data;

   // Configuration writes; an unknown index is ignored.
   always_comb begin
      word_length_in = word_length_ff;
      mixed_class_in = mixed_class_ff;
      if (csr_wr_en) begin
         case (csr_index)
            kca_pkg::CSR_WORD_LENGTH: word_length_in = csr_wr_data;
            kca_pkg::CSR_MIXED_CLASS: mixed_class_in = csr_wr_data[kca_pkg::CLASS_W-1:0];
            default: ;
         endcase
      end
   end

   // Request capture.
   always_comb begin
      base_in  = base_ff;
      annot_in = annot_ff;
      last_in  = last_ff;
      if (cmd.capture) begin
         base_in  = req_base_char;
         annot_in = req_annot_class;
         last_in  = req_end_of_sequence;
      end
   end

   // Next window state for the captured base.
   always_comb begin
      code      = kca_pkg::base_code(base_ff);
      wild_base = code[2];
      k_eff     = (word_length_ff == '0) ? kca_pkg::RUN_W'(1) : word_length_ff;

      if (bases_ff == '0 || annot_ff != last_annot_ff) begin
         same_next = kca_pkg::RUN_W'(1);
      end else begin
         same_next = kca_pkg::run_bump(same_run_ff);
      end
      word_next  = {word_ff[kca_pkg::WORD_BITS-3:0], (wild_base ? 2'b00 : code[1:0])};
      bases_next = kca_pkg::run_bump(bases_ff);
      valid_next = wild_base ? '0 : kca_pkg::run_bump(valid_run_ff);

      // Keep the low 2k bits of the word when the word is shorter than a slot.
      if ({k_eff, 1'b0} >= 6'(kca_pkg::WORD_BITS)) begin
         word_mask = '1;
      end else begin
         word_mask = kca_pkg::WORD_BITS'(
            ((kca_pkg::WORD_BITS+1)'(1) << {k_eff, 1'b0}) - (kca_pkg::WORD_BITS+1)'(1));
      end

      complete_next = (bases_next >= k_eff);
      wild_next     = complete_next && (valid_next < k_eff);
      class_next    = (same_next >= k_eff) ? annot_ff : mixed_class_ff;
   end

   // Window state and working result.
   always_comb begin
      word_in       = word_ff;
      bases_in      = bases_ff;
      valid_run_in  = valid_run_ff;
      same_run_in   = same_run_ff;
      last_annot_in = last_annot_ff;
      complete_in   = complete_ff;
      wild_in       = wild_ff;
      countable_in  = countable_ff;
      slot_in       = slot_ff;
      class_in      = class_ff;
      if (cmd.update) begin
         complete_in  = complete_next;
         wild_in      = wild_next;
         countable_in = complete_next && !wild_next &&
                        (class_next < kca_pkg::CLASS_W'(kca_pkg::CLASS_COUNT));
         if (complete_next && !wild_next) begin
            slot_in  = word_next & word_mask;
            class_in = class_next;
         end else begin
            slot_in  = '0;
            class_in = '0;
         end
         // The end of a sequence returns the window to its start.
         if (last_ff) begin
            word_in       = '0;
            bases_in      = '0;
            valid_run_in  = '0;
            same_run_in   = '0;
            last_annot_in = '0;
         end else begin
            word_in       = word_next;
            bases_in      = bases_next;
            valid_run_in  = valid_next;
            same_run_in   = same_next;
            last_annot_in = annot_ff;
         end
      end
   end

   // Saturating increment of the slot count.
   always_comb begin
      count_in = count_ff;
      if (cmd.modify) begin
         if (!countable_ff) begin
            count_in = '0;
         end else if (tbl_rd_data == kca_pkg::COUNT_MAX) begin
            count_in = kca_pkg::COUNT_MAX;
         end else begin
            count_in = tbl_rd_data + kca_pkg::COUNT_W'(1);
         end
      end
   end

   // Table ports: the clearing pass or the write-back of the increment.
   assign tbl_addr    = (kca_pkg::TABLE_AW'(class_ff) << kca_pkg::SLOT_BITS) |
                        kca_pkg::TABLE_AW'(slot_ff);
   assign tbl_wr_en   = cmd.clear || (cmd.modify && countable_ff);
   assign tbl_wr_addr = cmd.clear ? clr_addr_ff : tbl_addr;
   assign tbl_wr_data = cmd.clear ? '0 :
                        ((tbl_rd_data == kca_pkg::COUNT_MAX) ? kca_pkg::COUNT_MAX :
                         tbl_rd_data + kca_pkg::COUNT_W'(1));

   kca_ram #(
      .WIDTH (kca_pkg::COUNT_W),
      .DEPTH (kca_pkg::TABLE_DEPTH)
   ) u_count_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (cmd.lookup),
      .rd_addr (tbl_addr),
      .rd_data (tbl_rd_data)
   );

   // Clearing pass address.
   assign clr_addr_in = cmd.clear ? clr_addr_ff + kca_pkg::TABLE_AW'(1) : clr_addr_ff;
   assign status.clear_last =
      (clr_addr_ff == kca_pkg::TABLE_AW'(kca_pkg::TABLE_DEPTH - 1));

   // Result register and counters.
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_complete_in = rsp_complete_ff;
      rsp_wild_in     = rsp_wild_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_class_in    = rsp_class_ff;
      rsp_count_in    = rsp_count_ff;
      total_in        = total_ff;
      wild_cnt_in     = wild_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      if (cmd.deliver) begin
         rsp_valid_in    = 1'b1;
         rsp_complete_in = complete_ff;
         rsp_wild_in     = wild_ff;
         rsp_slot_in     = slot_ff;
         rsp_class_in    = class_ff;
         rsp_count_in    = count_ff;
         total_in        = total_ff + kca_pkg::TOTAL_W'(complete_ff);
         wild_cnt_in     = wild_cnt_ff + kca_pkg::TOTAL_W'(wild_ff);
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff <= kca_pkg::WORD_LENGTH_RESET;
         mixed_class_ff <= kca_pkg::MIXED_CLASS_RESET;
         word_ff        <= '0;
         bases_ff       <= '0;
         valid_run_ff   <= '0;
         same_run_ff    <= '0;
         last_annot_ff  <= '0;
         total_ff       <= '0;
         wild_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         clr_addr_ff    <= '0;
      end else begin
         word_length_ff <= word_length_in;
         mixed_class_ff <= mixed_class_in;
         word_ff        <= word_in;
         bases_ff       <= bases_in;
         valid_run_ff   <= valid_run_in;
         same_run_ff    <= same_run_in;
         last_annot_ff  <= last_annot_in;
         total_ff       <= total_in;
         wild_cnt_ff    <= wild_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         clr_addr_ff    <= clr_addr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      base_ff         <= base_in;
      annot_ff        <= annot_in;
      last_ff         <= last_in;
      complete_ff     <= complete_in;
      wild_ff         <= wild_in;
      countable_ff    <= countable_in;
      slot_ff         <= slot_in;
      class_ff        <= class_in;
      count_ff        <= count_in;
      rsp_complete_ff <= rsp_complete_in;
      rsp_wild_ff     <= rsp_wild_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_class_ff    <= rsp_class_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_window_complete = rsp_complete_ff;
   assign rsp_wild_window     = rsp_wild_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_word_class      = rsp_class_ff;
   assign rsp_new_count       = rsp_count_ff;
   assign rsp_total_windows   = total_ff;
   assign rsp_wild_windows    = wild_cnt_ff;

endmodule

// ===== hw/rtl/kmer_count_by_annotation.sv =====
// ----------------------------------------------------------------------------
// kmer_count_by_annotation
// Annotated k-mer counter: one nucleotide per request, one result per request.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries one nucleotide byte with its annotation class
// and an end-of-sequence mark; a request is taken when req_valid is high and
// req_stall is low. Each request gives exactly one result on the rsp_ channel,
// taken when rsp_valid is high and rsp_stall is low.
// A request steps through the controller states in order: it is taken in idle,
// the window state is advanced in update, the count table is read in lookup,
// the count is incremented and written back in modify, and the result is
// loaded in deliver once the result register is free. A new request is taken
// only after the last one has been delivered.
// After reset the block clears all 327680 entries of its count table, one entry
// a cycle, and holds req_stall high meanwhile. Configuration writes are to be
// made only while no request is in flight; the block does not enforce this.
// While the receiver stalls, the result holds; the next request may be taken
// and worked on, and waits before delivery until the result is taken.
// ----------------------------------------------------------------------------
module kmer_count_by_annotation (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kca_pkg::CHAR_W-1:0]        req_base_char,
   input  logic [kca_pkg::CLASS_W-1:0]       req_annot_class,
   input  logic                              req_end_of_sequence,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_window_complete,
   output logic                              rsp_wild_window,
   output logic [kca_pkg::SLOT_BITS-1:0]     rsp_slot_index,
   output logic [kca_pkg::CLASS_W-1:0]       rsp_word_class,
   output logic [kca_pkg::COUNT_W-1:0]       rsp_new_count,
   output logic [kca_pkg::TOTAL_W-1:0]       rsp_total_windows,
   output logic [kca_pkg::TOTAL_W-1:0]       rsp_wild_windows,
   // Configuration port.
   input  logic                              csr_wr_en,
   input  logic [kca_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kca_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   kca_pkg::kca_cmd_type    cmd;
   kca_pkg::kca_status_type status;

   // Sequencing of the clearing pass and of each request.
   kca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Window state, count table and result register.
   kca_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_base_char       (req_base_char),
      .req_annot_class     (req_annot_class),
      .req_end_of_sequence (req_end_of_sequence),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_window_complete (rsp_window_complete),
      .rsp_wild_window     (rsp_wild_window),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_word_class      (rsp_word_class),
      .rsp_new_count       (rsp_new_count),
      .rsp_total_windows   (rsp_total_windows),
      .rsp_wild_windows    (rsp_wild_windows)
   );

endmodule

// ===== tb/kmer_count_by_annotation_tb.sv =====
// ----------------------------------------------------------------------------
// kmer_count_by_annotation_tb
// Self-checking bench for the annotated k-mer counter. A scripted opening
// covers reset values, word-length extremes, wild bases, unmapped registers
// and out-of-table classes; a saturation burst and randomised nucleotide
// strands under changing settings and idle patterns follow. Every result is
// compared with its typed outcome or else a behavioural copy of the counter.
// ----------------------------------------------------------------------------
module kmer_count_by_annotation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 4 * kca_pkg::TABLE_DEPTH;
   localparam int unsigned LONG_HOLD      = 80;
   localparam int unsigned TAIL_CYCLES    = 12;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam int          SCRIPT_ROWS    = 26;

   // Register indexes that map to nothing; writes to them must be ignored.
   localparam logic [kca_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [kca_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 2'd3;

   typedef enum int {PRESS_NONE, PRESS_LONG_HOLD, PRESS_MID_DRAIN} pressure_type;

   typedef struct packed {
      logic                          window_complete;
      logic                          wild_window;
      logic [kca_pkg::SLOT_BITS-1:0] slot_index;
      logic [kca_pkg::CLASS_W-1:0]   word_class;
      logic [kca_pkg::COUNT_W-1:0]   new_count;
      logic [kca_pkg::TOTAL_W-1:0]   total_windows;
      logic [kca_pkg::TOTAL_W-1:0]   wild_windows;
   } window_outcome_type;

   typedef struct packed {
      logic                           csr_row;
      logic [kca_pkg::CSR_IDX_W-1:0]  reg_index;
      logic [kca_pkg::CSR_DATA_W-1:0] reg_value;
      logic [kca_pkg::CHAR_W-1:0]     ch;
      logic [kca_pkg::CLASS_W-1:0]    annot;
      logic                           eos;
      logic                           typed;
      window_outcome_type             golden;
   } script_row_type;

   logic                           clock;
   logic                           reset               = 1'b1;
   logic                           req_valid           = 1'b0;
   logic                           req_stall;
   logic [kca_pkg::CHAR_W-1:0]     req_base_char       = '0;
   logic [kca_pkg::CLASS_W-1:0]    req_annot_class     = '0;
   logic                           req_end_of_sequence = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall           = 1'b0;
   logic                           rsp_window_complete;
   logic                           rsp_wild_window;
   logic [kca_pkg::SLOT_BITS-1:0]  rsp_slot_index;
   logic [kca_pkg::CLASS_W-1:0]    rsp_word_class;
   logic [kca_pkg::COUNT_W-1:0]    rsp_new_count;
   logic [kca_pkg::TOTAL_W-1:0]    rsp_total_windows;
   logic [kca_pkg::TOTAL_W-1:0]    rsp_wild_windows;
   logic                           csr_wr_en           = 1'b0;
   logic [kca_pkg::CSR_IDX_W-1:0]  csr_index           = '0;
   logic [kca_pkg::CSR_DATA_W-1:0] csr_wr_data         = '0;

   kmer_count_by_annotation uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_base_char       (req_base_char),
      .req_annot_class     (req_annot_class),
      .req_end_of_sequence (req_end_of_sequence),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_window_complete (rsp_window_complete),
      .rsp_wild_window     (rsp_wild_window),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_word_class      (rsp_word_class),
      .rsp_new_count       (rsp_new_count),
      .rsp_total_windows   (rsp_total_windows),
      .rsp_wild_windows    (rsp_wild_windows),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Idle pattern for both sides and the long hold-off hand-over.
   int unsigned send_gap_pct   = 6;
   int unsigned recv_stall_pct = 45;
   bit          long_hold_ask  = 1'b0;
   int unsigned hold_left      = 0;

   // Outcomes still owed by the block, oldest first.
   window_outcome_type pending_outcomes [$];
   int unsigned        mismatches   = 0;
   int unsigned        quiet_cycles = 0;
   window_outcome_type observed;
   window_outcome_type wanted;

   // Shadow copy of the counter state and its settings.
   logic [61:0]                 roll_word;
   logic [kca_pkg::RUN_W-1:0]   strand_len;
   logic [kca_pkg::RUN_W-1:0]   acgt_run;
   logic [kca_pkg::RUN_W-1:0]   annot_run;
   logic [kca_pkg::CLASS_W-1:0] prev_annot;
   logic [kca_pkg::TOTAL_W-1:0] window_tally;
   logic [kca_pkg::TOTAL_W-1:0] wild_tally;
   logic [kca_pkg::RUN_W-1:0]   cfg_word_length;
   logic [kca_pkg::CLASS_W-1:0] cfg_mixed_class;
   logic [kca_pkg::COUNT_W-1:0] slot_counts [kca_pkg::TABLE_DEPTH];

   logic [kca_pkg::CHAR_W-1:0] acgt_chars [8] = '{8'h41, 8'h43, 8'h47, 8'h54,
                                                  8'h61, 8'h63, 8'h67, 8'h74};

   // Settings for the first random segments: word-length extremes first.
   logic [kca_pkg::RUN_W-1:0]   opening_lengths [6] = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd5, 5'd8};
   logic [kca_pkg::CLASS_W-1:0] opening_classes [6] = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd1};

   script_row_type script [SCRIPT_ROWS];

   function automatic logic [2:0] nucleotide_code(input logic [kca_pkg::CHAR_W-1:0] ch);
      // Clearing bit 5 folds lower case onto upper case for letters only.
      case (ch & 8'hDF)
         8'h41:   return kca_pkg::BASE_A;
         8'h43:   return kca_pkg::BASE_C;
         8'h47:   return kca_pkg::BASE_G;
         8'h54:   return kca_pkg::BASE_T;
         default: return kca_pkg::BASE_WILD;
      endcase
   endfunction

   function automatic logic [kca_pkg::RUN_W-1:0] run_plus_one(
      input logic [kca_pkg::RUN_W-1:0] r);
      return (r == kca_pkg::RUN_MAX) ? r : r + kca_pkg::RUN_W'(1);
   endfunction

   function automatic void clear_shadow();
      foreach (slot_counts[i])
         slot_counts[i] = '0;
      roll_word       = '0;
      strand_len      = '0;
      acgt_run        = '0;
      annot_run       = '0;
      prev_annot      = '0;
      window_tally    = '0;
      wild_tally      = '0;
      cfg_word_length = kca_pkg::WORD_LENGTH_RESET;
      cfg_mixed_class = kca_pkg::MIXED_CLASS_RESET;
   endfunction

   function automatic void shadow_register(input logic [kca_pkg::CSR_IDX_W-1:0] idx,
                                           input logic [kca_pkg::CSR_DATA_W-1:0] val);
      if (idx == kca_pkg::CSR_WORD_LENGTH)
         cfg_word_length = val;
      else if (idx == kca_pkg::CSR_MIXED_CLASS)
         cfg_mixed_class = val[kca_pkg::CLASS_W-1:0];
   endfunction

   // Advances the shadow state by one base and returns the outcome it owes.
   function automatic window_outcome_type tally_window(
      input logic [kca_pkg::CHAR_W-1:0] ch,
      input logic [kca_pkg::CLASS_W-1:0] annot,
      input logic eos);
      window_outcome_type          r;
      logic [2:0]                  code;
      logic [kca_pkg::RUN_W-1:0]   k;
      logic [61:0]                 word;
      logic [kca_pkg::CLASS_W-1:0] cls;
      int unsigned                 idx;
      r    = '0;
      code = nucleotide_code(ch);
      k    = (cfg_word_length == 0) ? 5'd1 : cfg_word_length;

      if (strand_len == 0 || annot != prev_annot)
         annot_run = 5'd1;
      else
         annot_run = run_plus_one(annot_run);
      prev_annot = annot;
      roll_word  = {roll_word[59:0], code[2] ? 2'b00 : code[1:0]};
      strand_len = run_plus_one(strand_len);
      acgt_run   = code[2] ? '0 : run_plus_one(acgt_run);

      if (strand_len >= k) begin
         r.window_complete = 1'b1;
         window_tally++;
         if (acgt_run < k) begin
            r.wild_window = 1'b1;
            wild_tally++;
         end else begin
            word         = roll_word & ((62'd1 << (2 * k)) - 62'd1);
            cls          = (annot_run >= k) ? annot : cfg_mixed_class;
            r.slot_index = word[kca_pkg::SLOT_BITS-1:0];
            r.word_class = cls;
            // Classes past the table are reported but never counted.
            if (cls < kca_pkg::CLASS_COUNT) begin
               idx = int'(cls) * kca_pkg::SLOT_COUNT +
                     int'(word[kca_pkg::SLOT_BITS-1:0]);
               if (slot_counts[idx] != kca_pkg::COUNT_MAX)
                  slot_counts[idx]++;
               r.new_count = slot_counts[idx];
            end
         end
      end
      r.total_windows = window_tally;
      r.wild_windows  = wild_tally;

      if (eos) begin
         roll_word  = '0;
         strand_len = '0;
         acgt_run   = '0;
         annot_run  = '0;
         prev_annot = '0;
      end
      return r;
   endfunction

   // Builders for the scripted opening.
   function automatic window_outcome_type outcome_of(input bit c, input bit w, input int s,
                                                     input int cl, input int n, input int t,
                                                     input int wd);
      window_outcome_type r;
      r.window_complete = c;
      r.wild_window     = w;
      r.slot_index      = kca_pkg::SLOT_BITS'(s);
      r.word_class      = kca_pkg::CLASS_W'(cl);
      r.new_count       = kca_pkg::COUNT_W'(n);
      r.total_windows   = kca_pkg::TOTAL_W'(t);
      r.wild_windows    = kca_pkg::TOTAL_W'(wd);
      return r;
   endfunction

   function automatic script_row_type ask(input logic [kca_pkg::CHAR_W-1:0] ch,
                                          input logic [kca_pkg::CLASS_W-1:0] annot,
                                          input logic eos);
      script_row_type row;
      row       = '0;
      row.ch    = ch;
      row.annot = annot;
      row.eos   = eos;
      return row;
   endfunction

   function automatic script_row_type ask_known(input logic [kca_pkg::CHAR_W-1:0] ch,
                                                input logic [kca_pkg::CLASS_W-1:0] annot,
                                                input logic eos,
                                                input window_outcome_type golden);
      script_row_type row;
      row        = ask(ch, annot, eos);
      row.typed  = 1'b1;
      row.golden = golden;
      return row;
   endfunction

   function automatic script_row_type set_reg(input logic [kca_pkg::CSR_IDX_W-1:0] idx,
                                              input logic [kca_pkg::CSR_DATA_W-1:0] val);
      script_row_type row;
      row           = '0;
      row.csr_row   = 1'b1;
      row.reg_index = idx;
      row.reg_value = val;
      return row;
   endfunction

   function automatic logic [kca_pkg::CLASS_W-1:0] pick_annot();
      // Now and then an annotation beyond the table.
      return ($urandom_range(19) == 0) ? kca_pkg::CLASS_W'($urandom_range(5, 7))
                                       : kca_pkg::CLASS_W'($urandom_range(0, 4));
   endfunction

   // Offers one request, holding it until taken, then records its outcome.
   task automatic offer_base(input logic [kca_pkg::CHAR_W-1:0] ch,
                             input logic [kca_pkg::CLASS_W-1:0] annot,
                             input logic eos, input logic typed,
                             input window_outcome_type golden);
      window_outcome_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_base_char       <= ch;
      req_annot_class     <= annot;
      req_end_of_sequence <= eos;
      do
         @(posedge clock);
      while (req_stall);
      predicted = tally_window(ch, annot, eos);
      pending_outcomes.push_back(typed ? golden : predicted);
   endtask

   // Stops offering and waits until every outstanding result has come back.
   task automatic await_drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_outcomes.size() != 0);
   endtask

   task automatic write_register(input logic [kca_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [kca_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_register(idx, val);
      @(posedge clock);
   endtask

   // One random segment: new settings, then strands of random content.
   task automatic run_segment(input logic [kca_pkg::RUN_W-1:0] k,
                              input logic [kca_pkg::CLASS_W-1:0] mix,
                              input int unsigned quota, input pressure_type pressure);
      int unsigned                 sent;
      int unsigned                 span;
      int unsigned                 pos;
      logic [kca_pkg::CLASS_W-1:0] annot;
      logic [kca_pkg::CHAR_W-1:0]  ch;
      bit                          uniform;
      bit                          closes;
      await_drain();
      write_register(kca_pkg::CSR_WORD_LENGTH, k);
      // Upper data bits are random; only the low three belong to the class.
      write_register(kca_pkg::CSR_MIXED_CLASS, {2'($urandom_range(3)), mix});
      if (pressure == PRESS_LONG_HOLD)
         long_hold_ask = 1'b1;
      sent = 0;
      while (sent < quota) begin
         span    = ($urandom_range(5) == 0) ? $urandom_range(1, 4)
                                            : $urandom_range(1, int'(k) + 10);
         uniform = ($urandom_range(9) < 6);
         closes  = ($urandom_range(9) != 0);
         annot   = pick_annot();
         for (pos = 0; pos < span && sent < quota; pos++) begin
            if (pressure == PRESS_MID_DRAIN && sent == quota / 2)
               await_drain();
            if (!uniform && $urandom_range(4) == 0)
               annot = pick_annot();
            // Mostly clean bases; the odd raw byte of any value.
            ch = ($urandom_range(99) < 3) ? kca_pkg::CHAR_W'($urandom_range(255))
                                          : acgt_chars[$urandom_range(7)];
            offer_base(ch, annot, closes && pos == span - 1, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // Receiver: random stalls, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (long_hold_ask) begin
         long_hold_ask = 1'b0;
         hold_left     = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Result checking and the watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            observed = {rsp_window_complete, rsp_wild_window, rsp_slot_index,
                        rsp_word_class, rsp_new_count, rsp_total_windows,
                        rsp_wild_windows};
            if (pending_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("result taken with no request outstanding");
            end else begin
               wanted = pending_outcomes.pop_front();
               if (observed.window_complete !== wanted.window_complete ||
                   observed.wild_window !== wanted.wild_window ||
                   observed.slot_index !== wanted.slot_index ||
                   observed.word_class !== wanted.word_class ||
                   observed.new_count !== wanted.new_count ||
                   observed.total_windows !== wanted.total_windows ||
                   observed.wild_windows !== wanted.wild_windows) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("expected: done=%b wild=%b slot=%h class=%0d count=%0d %0d/%0d",
                              wanted.window_complete, wanted.wild_window,
                              wanted.slot_index, wanted.word_class, wanted.new_count,
                              wanted.total_windows, wanted.wild_windows);
                     $display("actual:   done=%b wild=%b slot=%h class=%0d count=%0d %0d/%0d",
                              observed.window_complete, observed.wild_window,
                              observed.slot_index, observed.word_class, observed.new_count,
                              observed.total_windows, observed.wild_windows);
                  end
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Stimulus sequence.
   initial begin : stimulus
      int                          row;
      int unsigned                 n;
      int                          mode;
      int                          seg;
      int                          idx;
      logic [kca_pkg::RUN_W-1:0]   k;
      logic [kca_pkg::CLASS_W-1:0] mix;
      pressure_type                pressure;

      clear_shadow();
      // Opening script. Typed outcomes follow straight from the rules; the
      // mixed-class strands are left to the shadow model.
      script = '{
         ask_known(8'h41, 3'd0, 1'b1, outcome_of(0, 0, 0, 0, 0, 0, 0)),
         set_reg(kca_pkg::CSR_WORD_LENGTH, 5'd1),
         ask_known(8'h54, 3'd4, 1'b0, outcome_of(1, 0, 3, 4, 1, 1, 0)),
         ask_known(8'h78, 3'd0, 1'b0, outcome_of(1, 1, 0, 0, 0, 2, 1)),
         ask_known(8'h67, 3'd2, 1'b1, outcome_of(1, 0, 2, 2, 1, 3, 1)),
         ask_known(8'hFF, 3'd7, 1'b0, outcome_of(1, 1, 0, 0, 0, 4, 2)),
         ask_known(8'h63, 3'd7, 1'b0, outcome_of(1, 0, 1, 7, 0, 5, 2)),
         ask_known(8'h00, 3'd0, 1'b1, outcome_of(1, 1, 0, 0, 0, 6, 3)),
         set_reg(kca_pkg::CSR_WORD_LENGTH, 5'd0),
         ask_known(8'h61, 3'd1, 1'b1, outcome_of(1, 0, 0, 1, 1, 7, 3)),
         set_reg(CSR_UNMAPPED_LO, 5'd31),
         set_reg(CSR_UNMAPPED_HI, 5'd7),
         ask_known(8'h41, 3'd1, 1'b1, outcome_of(1, 0, 0, 1, 2, 8, 3)),
         set_reg(kca_pkg::CSR_WORD_LENGTH, 5'd3),
         set_reg(kca_pkg::CSR_MIXED_CLASS, 5'd0),
         ask(8'h43, 3'd3, 1'b0),
         ask(8'h47, 3'd3, 1'b0),
         ask(8'h54, 3'd1, 1'b0),
         ask(8'h41, 3'd1, 1'b1),
         set_reg(kca_pkg::CSR_WORD_LENGTH, 5'd2),
         set_reg(kca_pkg::CSR_MIXED_CLASS, 5'd7),
         ask(8'h41, 3'd2, 1'b0),
         ask(8'h63, 3'd0, 1'b1),
         set_reg(kca_pkg::CSR_WORD_LENGTH, 5'd31),
         set_reg(kca_pkg::CSR_MIXED_CLASS, 5'd5),
         ask(8'h80, 3'd4, 1'b1)
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < SCRIPT_ROWS; row++) begin
         if (script[row].csr_row) begin
            await_drain();
            write_register(script[row].reg_index, script[row].reg_value);
         end else begin
            offer_base(script[row].ch, script[row].annot, script[row].eos,
                       script[row].typed, script[row].golden);
         end
      end

      // Drive one slot of one class past its saturation point.
      await_drain();
      write_register(kca_pkg::CSR_WORD_LENGTH, 5'd1);
      write_register(kca_pkg::CSR_MIXED_CLASS, 5'd0);
      for (n = 0; n < 260; n++)
         offer_base(n[0] ? 8'h47 : 8'h67, 3'd3, 1'($urandom_range(1)), 1'b0, '0);

      // Random segments under three idle patterns: sender light and receiver
      // heavy, then the reverse, then no random idling.
      for (mode = 0; mode < 3; mode++) begin
         send_gap_pct   = (mode == 0) ? 6 : (mode == 1) ? 45 : 0;
         recv_stall_pct = (mode == 0) ? 45 : (mode == 1) ? 6 : 0;
         for (seg = 0; seg < 4; seg++) begin
            idx = mode * 4 + seg;
            if (idx < 6) begin
               k   = opening_lengths[idx];
               mix = opening_classes[idx];
            end else begin
               k   = kca_pkg::RUN_W'($urandom_range(31));
               mix = kca_pkg::CLASS_W'($urandom_range(7));
            end
            pressure = (seg == 1) ? PRESS_LONG_HOLD :
                       (seg == 2) ? PRESS_MID_DRAIN : PRESS_NONE;
            run_segment(k, mix, 2 + int'(k), pressure);
         end
      end

      await_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
